// ===== design/cmdu64_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdu64_pkg
// Shared types and constants for the ceiling multiply-divide datapath.
// ----------------------------------------------------------------------------
package cmdu64_pkg;

    localparam int unsigned OpW   = 64;
    localparam int unsigned ProdW = 2 * OpW;
    localparam int unsigned HalfW = OpW / 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // One word in flight through the divider chain.
    typedef struct packed {
        logic              valid;
        t_status           status;
        logic [OpW-1:0]    rem;     // partial remainder, below the divisor
        logic [OpW-1:0]    divisor;
        logic [OpW-1:0]    nq;      // low product bits on top, quotient bits shifted in below
    } t_cell;

endpackage

// ===== design/cmdu64_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdu64_mul
// Two-stage 64x64 unsigned multiplier: four 32x32 partial products, then sum.
// ----------------------------------------------------------------------------
module cmdu64_mul
    import cmdu64_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [OpW-1:0]   i_a,
    input  logic [OpW-1:0]   i_b,
    input  logic [OpW-1:0]   i_divisor,
    output logic             o_valid,
    output logic [ProdW-1:0] o_product,
    output logic [OpW-1:0]   o_divisor
);

    logic             r_pp_valid;
    logic [OpW-1:0]   r_pp_ll;
    logic [OpW-1:0]   r_pp_lh;
    logic [OpW-1:0]   r_pp_hl;
    logic [OpW-1:0]   r_pp_hh;
    logic [OpW-1:0]   r_pp_div;

    logic             r_sum_valid;
    logic [ProdW-1:0] r_sum;
    logic [OpW-1:0]   r_sum_div;

    logic [ProdW-1:0] n_sum;

    always_comb begin
        n_sum = {{OpW{1'b0}}, r_pp_ll}
              + {{HalfW{1'b0}}, r_pp_lh, {HalfW{1'b0}}}
              + {{HalfW{1'b0}}, r_pp_hl, {HalfW{1'b0}}}
              + {r_pp_hh, {OpW{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp_valid  <= 1'b0;
            r_sum_valid <= 1'b0;
        end else if (i_en) begin
            r_pp_valid  <= i_valid;
            r_sum_valid <= r_pp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_ll   <= OpW'(i_a[HalfW-1:0])   * OpW'(i_b[HalfW-1:0]);
            r_pp_lh   <= OpW'(i_a[HalfW-1:0])   * OpW'(i_b[OpW-1:HalfW]);
            r_pp_hl   <= OpW'(i_a[OpW-1:HalfW]) * OpW'(i_b[HalfW-1:0]);
            r_pp_hh   <= OpW'(i_a[OpW-1:HalfW]) * OpW'(i_b[OpW-1:HalfW]);
            r_pp_div  <= i_divisor;
            r_sum     <= n_sum;
            r_sum_div <= r_pp_div;
        end
    end

    assign o_valid   = r_sum_valid;
    assign o_product = r_sum;
    assign o_divisor = r_sum_div;

endmodule

// ===== design/cmdu64_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdu64_cell
// One restoring division step: shift in a product bit, trial subtract,
// emit one quotient bit.
// ----------------------------------------------------------------------------
module cmdu64_cell
    import cmdu64_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);

    t_cell          r_cell;
    t_cell          n_cell;
    logic [OpW:0]   w_trial;
    logic [OpW+1:0] w_diff;
    logic           w_ge;

    always_comb begin
        w_trial = {i_cell.rem, i_cell.nq[OpW-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, i_cell.divisor};
        w_ge    = ~w_diff[OpW+1];
        n_cell         = i_cell;
        n_cell.rem     = w_ge ? w_diff[OpW-1:0] : w_trial[OpW-1:0];
        n_cell.nq      = {i_cell.nq[OpW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

// ===== design/ceil_mul_div_u64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceil_mul_div_u64
// ceil(multiplicand * multiplier / divisor) over a 128-bit product, with status.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless the output stalls. Each result passes
// through two multiplier stages, one check stage that flags a zero divisor
// or a high product half not below the divisor (quotient overflow), a row of
// 64 division cells that each resolve one quotient bit, and a rounding and
// output register. Results leave in order. The whole row moves as one; while
// an output word waits on m_axis_tready the row holds and s_axis_tready
// drops, otherwise a new word is taken every cycle.
module ceil_mul_div_u64
    import cmdu64_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [3*OpW-1:0] s_axis_tdata,  // multiplicand, multiplier, divisor
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OpW-1:0]   m_axis_tdata,  // quotient_ceiling
    output logic [1:0]       m_axis_tuser   // status
);

    localparam int unsigned NumCells = OpW;

    logic             w_adv;
    logic             w_mul_valid;
    logic [ProdW-1:0] w_product;
    logic [OpW-1:0]   w_mul_div;

    t_cell            r_head;
    t_cell            n_head;
    t_cell            w_chain [NumCells+1];

    logic             r_out_valid;
    logic [OpW-1:0]   r_out_q;
    t_status          r_out_status;
    logic [OpW-1:0]   n_out_q;
    t_status          n_out_status;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    cmdu64_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_valid   (s_axis_tvalid),
        .i_a       (s_axis_tdata[OpW-1:0]),
        .i_b       (s_axis_tdata[2*OpW-1:OpW]),
        .i_divisor (s_axis_tdata[3*OpW-1:2*OpW]),
        .o_valid   (w_mul_valid),
        .o_product (w_product),
        .o_divisor (w_mul_div)
    );

    // With the high half below the divisor, the upper 64 steps give no
    // quotient bits and leave the high half as the remainder.
    always_comb begin
        n_head.valid   = w_mul_valid;
        n_head.rem     = w_product[ProdW-1:OpW];
        n_head.nq      = w_product[OpW-1:0];
        n_head.divisor = w_mul_div;
        if (w_mul_div == '0) begin
            n_head.status = ST_DIV_ZERO;
        end else if (w_product[ProdW-1:OpW] >= w_mul_div) begin
            n_head.status = ST_OVERFLOW;
        end else begin
            n_head.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else if (w_adv) begin
            r_head <= n_head;
        end
    end

    assign w_chain[0] = r_head;

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        cmdu64_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    // Round up on a nonzero remainder; an all-ones quotient cannot round.
    always_comb begin
        n_out_status = w_chain[NumCells].status;
        n_out_q      = w_chain[NumCells].nq;
        if (n_out_status == ST_OK && w_chain[NumCells].rem != '0) begin
            if (&w_chain[NumCells].nq) begin
                n_out_status = ST_OVERFLOW;
            end else begin
                n_out_q = w_chain[NumCells].nq + OpW'(1);
            end
        end
        if (n_out_status != ST_OK) begin
            n_out_q = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_chain[NumCells].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_q      <= n_out_q;
            r_out_status <= n_out_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_q;
    assign m_axis_tuser  = r_out_status;

endmodule

// ===== design/ceil_mul_div_u64_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceil_mul_div_u64_chk
// Port-level checks for the ceiling multiply-divide block, bound to the top.
// ----------------------------------------------------------------------------
module ceil_mul_div_u64_chk
    import cmdu64_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [3*OpW-1:0] s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OpW-1:0]   m_axis_tdata,
    input logic [1:0]       m_axis_tuser
);

    // Hold a stalled output word.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_DIV_ZERO
                           || m_axis_tuser == ST_OVERFLOW))
        else $error("undefined status code");

    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("nonzero quotient with error status");

    // An empty output register never blocks the input side.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with output register empty");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind ceil_mul_div_u64 ceil_mul_div_u64_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
